>>> rtl/msf_pkg.sv
`default_nettype none

package msf_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [3:0] {
        MODE_EQ,
        MODE_NE,
        MODE_GT,
        MODE_GE,
        MODE_LT,
        MODE_LE,
        MODE_INC_BY,
        MODE_DEC_BY,
        MODE_CHG_BY,
        MODE_EQ_LAST,
        MODE_NE_LAST,
        MODE_GT_LAST,
        MODE_GE_LAST,
        MODE_LT_LAST,
        MODE_LE_LAST,
        MODE_ANY
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_VALUE,
        REG_SIGNED,
        REG_SIZE
    } reg_idx_t;

    // code 3 is not named: it reads as a word access
    typedef enum logic [1:0] {
        SIZE_BYTE,
        SIZE_HALF,
        SIZE_WORD
    } size_t;

    typedef struct packed {
        mode_t            mode;
        logic [DataW-1:0] value;
        logic             sgn_mode;
        logic [1:0]       size;
    } cfg_t;

    typedef struct packed {
        logic [DataW-1:0] widened;
        logic             keep;
        logic             changed;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/msf_cfg_regs.sv
`default_nettype none

module msf_cfg_regs
    import msf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [DataW-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:   cfg_next.mode     = mode_t'(cfg_data[3:0]);
                REG_VALUE:  cfg_next.value    = cfg_data;
                REG_SIGNED: cfg_next.sgn_mode = cfg_data[0];
                REG_SIZE:   cfg_next.size     = cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msf_eval.sv
`default_nettype none

module msf_eval
    import msf_pkg::*;
(
    input  wire cfg_t             cfg,
    input  wire logic [DataW-1:0] raw,
    input  wire logic [DataW-1:0] ref_in,
    input  wire logic             first,
    output res_t                  res
);

    logic [DataW-1:0] v;
    logic [DataW-1:0] r;
    logic [DataW-1:0] c;
    logic [DataW-1:0] v_minus_r;
    logic [DataW-1:0] r_minus_v;
    logic [DataW-1:0] abs_diff;
    logic             sign_bit;
    logic             v_gt_c;
    logic             c_gt_v;
    logic             v_gt_r;
    logic             r_gt_v;
    logic             r_gt_v_uns;
    logic             keep;

    // flipping the sign bit turns a signed order into an unsigned one
    function automatic logic greater(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                                     input logic sgn);
        logic [DataW-1:0] fa;
        logic [DataW-1:0] fb;
        fa = a;
        fb = b;
        fa[DataW-1] = a[DataW-1] ^ sgn;
        fb[DataW-1] = b[DataW-1] ^ sgn;
        return fa > fb;
    endfunction

    always_comb
    begin
        unique case (cfg.size)
            SIZE_BYTE:
            begin
                sign_bit = cfg.sgn_mode & raw[7];
                v = {{(DataW-8){sign_bit}}, raw[7:0]};
            end
            SIZE_HALF:
            begin
                sign_bit = cfg.sgn_mode & raw[15];
                v = {{(DataW-16){sign_bit}}, raw[15:0]};
            end
            default:
            begin
                sign_bit = 1'b0;
                v = raw;
            end
        endcase
    end

    assign r = first ? v : ref_in;
    assign c = cfg.value;

    assign v_minus_r  = v - r;
    assign r_minus_v  = r - v;
    assign r_gt_v_uns = r > v;

    always_comb
    begin
        if (cfg.sgn_mode)
        begin
            // most negative difference wraps back onto itself
            abs_diff = r_minus_v[DataW-1] ? v_minus_r : r_minus_v;
        end
        else
        begin
            abs_diff = r_gt_v_uns ? r_minus_v : v_minus_r;
        end
    end

    assign v_gt_c = greater(v, c, cfg.sgn_mode);
    assign c_gt_v = greater(c, v, cfg.sgn_mode);
    assign v_gt_r = greater(v, r, cfg.sgn_mode);
    assign r_gt_v = greater(r, v, cfg.sgn_mode);

    always_comb
    begin
        unique case (cfg.mode)
            MODE_EQ:      keep = (v == c);
            MODE_NE:      keep = (v != c);
            MODE_GT:      keep = v_gt_c;
            MODE_GE:      keep = !c_gt_v;
            MODE_LT:      keep = c_gt_v;
            MODE_LE:      keep = !v_gt_c;
            MODE_INC_BY:  keep = (v_minus_r == c);
            MODE_DEC_BY:  keep = (r_minus_v == c);
            MODE_CHG_BY:  keep = (abs_diff == c);
            MODE_EQ_LAST: keep = (v == r);
            MODE_NE_LAST: keep = (v != r);
            MODE_GT_LAST: keep = v_gt_r;
            MODE_GE_LAST: keep = !r_gt_v;
            MODE_LT_LAST: keep = r_gt_v;
            MODE_LE_LAST: keep = !v_gt_r;
            MODE_ANY:     keep = 1'b1;
        endcase
    end

    assign res.widened = v;
    assign res.keep    = keep;
    assign res.changed = (v != r);

endmodule

`default_nettype wire

>>> rtl/memory_scan_filter_top.sv
// Path: an accepted input beat passes the input register and then the result
// register. Throughput: one candidate per cycle while out_stall is low; input
// register, one level of compare logic, result register.
// Reset (rst_n, async, active low): pipeline empty, all config registers zero.
// Config writes are taken every cycle (cfg_ready is held high).
`default_nettype none

module memory_scan_filter_top
    import msf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [DataW-1:0] cfg_data,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [DataW-1:0] cand_address,
    input  wire logic [DataW-1:0] raw_data,
    input  wire logic [DataW-1:0] reference_value,
    input  wire logic             first_pass,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [DataW-1:0]      out_address,
    output logic [DataW-1:0]      widened_value,
    output logic                  keep,
    output logic                  changed_flag
);

    cfg_t cfg;
    res_t res;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [DataW-1:0] s1_addr_reg;
    logic [DataW-1:0] s1_raw_reg;
    logic [DataW-1:0] s1_ref_reg;
    logic             s1_first_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [DataW-1:0] out_addr_reg;
    res_t             out_res_reg;

    logic             out_load;
    logic             s1_load;

    msf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msf_eval u_eval (
        .cfg    (cfg),
        .raw    (s1_raw_reg),
        .ref_in (s1_ref_reg),
        .first  (s1_first_reg),
        .res    (res)
    );

    // result stage frees up when empty or when its beat leaves this cycle
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || out_load;
    assign in_stall = !s1_load;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_load)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_addr_reg  <= cand_address;
            s1_raw_reg   <= raw_data;
            s1_ref_reg   <= reference_value;
            s1_first_reg <= first_pass;
        end
        if (out_load && s1_valid_reg)
        begin
            out_addr_reg <= s1_addr_reg;
            out_res_reg  <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_address   = out_addr_reg;
    assign widened_value = out_res_reg.widened;
    assign keep          = out_res_reg.keep;
    assign changed_flag  = out_res_reg.changed;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost at input register");

    a_any_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg.mode == MODE_ANY) |-> keep)
        else $error("any mode dropped a candidate");

    a_eq_last_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg.mode == MODE_EQ_LAST) |-> (keep == !changed_flag))
        else $error("equal-to-last disagrees with changed flag");

endmodule

`default_nettype wire
